FILE: sv/periodic_timer_overrun_counter_top_defines.svh
// Assertion macros for the periodic timer overrun counter.
`ifndef PERIODIC_TIMER_OVERRUN_COUNTER_TOP_DEFINES_SVH
`define PERIODIC_TIMER_OVERRUN_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every edge out of reset.
`define PTOC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ptoc assertion failed");
// Consequence must hold in the cycle after the antecedent.
`define PTOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptoc assertion failed");
`else
`define PTOC_ASSERT(lbl, clk, rstn, prop)
`define PTOC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/ptoc_pkg.sv
// Shared types and constants of the periodic timer overrun counter.
`default_nettype none

package ptoc_pkg;

    localparam int TIME_W  = 63;
    localparam int TICK_W  = 64;
    localparam int RATIO_W = 32;
    localparam int ALU_W   = 64;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register indexes of the config port
    localparam logic [IDX_W-1:0] REG_START    = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd1;
    localparam logic [IDX_W-1:0] REG_NUMER    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DENOM    = 3'd3;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [RATIO_W-1:0] ratio_t;

    typedef struct packed {
        time_t expirations;
        time_t deadline_ns;
        tick_t deadline_ticks;
        logic  still_armed;
        logic  saturated;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/ptoc_alu.sv
// Shared 64-bit add/subtract unit with carry out.
`default_nettype none

module ptoc_alu (
    input  wire logic [ptoc_pkg::ALU_W-1:0] a,
    input  wire logic [ptoc_pkg::ALU_W-1:0] b,
    input  wire logic                       sub,
    output logic      [ptoc_pkg::ALU_W:0]   sum
);
    import ptoc_pkg::*;

    logic [ALU_W-1:0] b_op;

    // sub: a + ~b + 1; carry out set means a >= b
    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};

endmodule

`default_nettype wire

FILE: sv/ptoc_core.sv
// Sequencer and datapath: deadline check, overrun division, tick conversion.
`default_nettype none

module ptoc_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic            take,
    input  wire ptoc_pkg::time_t now_ns,
    input  wire ptoc_pkg::time_t cur_deadline,
    input  wire logic            cur_armed,
    input  wire ptoc_pkg::time_t interval,
    input  wire ptoc_pkg::ratio_t numer,
    input  wire ptoc_pkg::ratio_t denom,
    output logic                 idle,
    output logic                 done,
    output ptoc_pkg::res_t       res
);
    import ptoc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CMP  = 4'd1;
    localparam logic [3:0] ST_DIV1 = 4'd2;
    localparam logic [3:0] ST_SUBR = 4'd3;
    localparam logic [3:0] ST_ADDI = 4'd4;
    localparam logic [3:0] ST_INC  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_DIV2 = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [CNT_W-1:0] DIV1_LAST = CNT_W'(TIME_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(RATIO_W - 1);
    localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(ALU_W + RATIO_W - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    time_t            now_reg, now_next;
    logic [ALU_W-1:0] hi_reg, hi_next;
    logic [ALU_W-1:0] lo_reg, lo_next;
    ratio_t           rem_reg, rem_next;
    time_t            exp_reg, exp_next;
    time_t            nd_reg, nd_next;
    logic             armed_reg, armed_next;
    logic             sat_reg, sat_next;

    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_sum;
    ratio_t           n_eff;
    logic             cnt_last;

    ptoc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign n_eff    = (numer == '0) ? RATIO_W'(1) : numer;
    assign cnt_last = (cnt_reg == '0);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        exp_next   = exp_reg;
        nd_next    = nd_reg;
        armed_next = armed_reg;
        sat_next   = sat_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    now_next   = now_ns;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                // now - deadline; carry out means due
                alu_a      = {1'b0, now_reg};
                alu_b      = {1'b0, cur_deadline};
                alu_sub    = 1'b1;
                exp_next   = '0;
                sat_next   = 1'b0;
                nd_next    = cur_deadline;
                armed_next = cur_armed;
                if (cur_armed && alu_sum[ALU_W] && (interval != '0)) begin
                    hi_next    = '0;
                    lo_next    = {1'b0, alu_sum[TIME_W-1:0]};
                    cnt_next   = DIV1_LAST;
                    state_next = ST_DIV1;
                end else if (cur_armed && alu_sum[ALU_W]) begin
                    // one-shot fired
                    exp_next   = TIME_W'(1);
                    armed_next = 1'b0;
                    nd_next    = '0;
                    state_next = ST_DONE;
                end else if (cur_armed) begin
                    hi_next    = '0;
                    lo_next    = {{(ALU_W-RATIO_W){1'b0}}, denom};
                    cnt_next   = MUL_LAST;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV1: begin
                // restoring divide: elapsed / interval, one bit per cycle
                alu_a   = {hi_reg[TIME_W-1:0], lo_reg[TIME_W-1]};
                alu_b   = {1'b0, interval};
                alu_sub = 1'b1;
                hi_next = alu_sum[ALU_W] ? {1'b0, alu_sum[TIME_W-1:0]}
                                         : {1'b0, hi_reg[TIME_W-2:0], lo_reg[TIME_W-1]};
                lo_next = {1'b0, lo_reg[TIME_W-2:0], alu_sum[ALU_W]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_last) begin
                    state_next = ST_SUBR;
                end
            end
            ST_SUBR: begin
                // now - remainder = deadline + missed * interval
                alu_a      = {1'b0, now_reg};
                alu_b      = {1'b0, hi_reg[TIME_W-1:0]};
                alu_sub    = 1'b1;
                hi_next    = alu_sum[ALU_W-1:0];
                state_next = ST_ADDI;
            end
            ST_ADDI: begin
                alu_a      = hi_reg;
                alu_b      = {1'b0, interval};
                sat_next   = alu_sum[TIME_W];
                nd_next    = alu_sum[TIME_W] ? TIME_MAX : alu_sum[TIME_W-1:0];
                state_next = ST_INC;
            end
            ST_INC: begin
                alu_a      = {1'b0, lo_reg[TIME_W-1:0]};
                alu_b      = ALU_W'(1);
                exp_next   = alu_sum[TIME_W] ? TIME_MAX : alu_sum[TIME_W-1:0];
                hi_next    = '0;
                lo_next    = {{(ALU_W-RATIO_W){1'b0}}, denom};
                cnt_next   = MUL_LAST;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // shift-add, multiplier LSB first, product low half into lo
                alu_a    = hi_reg;
                alu_b    = lo_reg[0] ? {1'b0, nd_reg} : '0;
                hi_next  = alu_sum[ALU_W:1];
                lo_next  = {{(ALU_W-RATIO_W){1'b0}}, alu_sum[0], lo_reg[RATIO_W-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_last) begin
                    rem_next   = '0;
                    cnt_next   = DIV2_LAST;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                // 96-bit product / numer, quotient shifts in at the bottom
                alu_a    = {{(ALU_W-RATIO_W-1){1'b0}}, rem_reg, hi_reg[ALU_W-1]};
                alu_b    = {{(ALU_W-RATIO_W){1'b0}}, n_eff};
                alu_sub  = 1'b1;
                hi_next  = {hi_reg[ALU_W-2:0], lo_reg[RATIO_W-1]};
                lo_next  = {{(ALU_W-RATIO_W){1'b0}}, lo_reg[RATIO_W-2:0], alu_sum[ALU_W]};
                rem_next = alu_sum[ALU_W] ? alu_sum[RATIO_W-1:0]
                                          : {rem_reg[RATIO_W-2:0], hi_reg[ALU_W-1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                done = 1'b1;
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        now_reg   <= now_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        rem_reg   <= rem_next;
        exp_reg   <= exp_next;
        nd_reg    <= nd_next;
        armed_reg <= armed_next;
        sat_reg   <= sat_next;
    end

    assign idle = (state_reg == ST_IDLE);

    always_comb begin
        res.expirations    = exp_reg;
        res.deadline_ns    = armed_reg ? nd_reg : '0;
        res.deadline_ticks = armed_reg ? {hi_reg[RATIO_W-1:0], lo_reg[RATIO_W-1:0]} : '0;
        res.still_armed    = armed_reg;
        res.saturated      = sat_reg;
    end

endmodule

`default_nettype wire

FILE: sv/periodic_timer_overrun_counter_top.sv
// Top level of the periodic timer overrun counter.
//
// Usage: program the timer through the config write port (cfg_we, cfg_index,
// cfg_wdata): index 0 start deadline, 1 reload interval (0 = one-shot),
// 2 tick ratio divisor, 3 tick ratio multiplier. Writing start or interval
// re-arms the timer at the start deadline, or disarms it when both are zero.
// Each s_ transaction carries the current time s_now_ns; each produces one m_
// transaction with the expiration count, the next deadline in ns and ticks,
// the armed flag and the clamp flag.
// A disarmed timer and a firing one-shot go straight to the result; an armed
// timer that is not due runs the shift-add multiply and the tick division,
// and a due periodic timer runs the overrun division before both. These
// share one 64-bit adder, and each works one bit at a time.
// One transaction is in flight at a time; s_ready is high while the
// sequencer is idle, even if a result still sits in the output register.
// If m_ready is held low while the output register is full, the finished result
// waits in the sequencer until it drains. Reset (aresetn, synchronous, active low)
// disarms the timer, sets both ratio registers to 1 and empties the output.
`default_nettype none

module periodic_timer_overrun_counter_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [ptoc_pkg::IDX_W-1:0] cfg_index,
    input  wire ptoc_pkg::time_t            cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire ptoc_pkg::time_t            s_now_ns,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output ptoc_pkg::time_t                 m_expirations,
    output ptoc_pkg::time_t                 m_deadline_ns,
    output ptoc_pkg::tick_t                 m_deadline_ticks,
    output logic                            m_still_armed,
    output logic                            m_saturated
);
    import ptoc_pkg::*;

    time_t  start_reg, start_next;
    time_t  interval_reg, interval_next;
    ratio_t numer_reg, numer_next;
    ratio_t denom_reg, denom_next;
    time_t  nd_reg, nd_next;
    logic   armed_reg, armed_next;
    logic   m_valid_reg, m_valid_next;
    res_t   out_reg, out_next;

    logic   core_idle;
    logic   core_done;
    logic   take;
    logic   s_accept;
    res_t   core_res;

    // output register free or draining this cycle
    assign take     = !m_valid_reg || m_ready;
    assign s_ready  = core_idle;
    assign s_accept = s_valid && s_ready;

    ptoc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_accept),
        .take         (take),
        .now_ns       (s_now_ns),
        .cur_deadline (nd_reg),
        .cur_armed    (armed_reg),
        .interval     (interval_reg),
        .numer        (numer_reg),
        .denom        (denom_reg),
        .idle         (core_idle),
        .done         (core_done),
        .res          (core_res)
    );

    // config writes and timer state
    always_comb begin
        start_next    = start_reg;
        interval_next = interval_reg;
        numer_next    = numer_reg;
        denom_next    = denom_reg;
        nd_next       = nd_reg;
        armed_next    = armed_reg;
        priority if (cfg_we) begin
            unique case (cfg_index)
                REG_START: begin
                    start_next = cfg_wdata;
                    armed_next = (cfg_wdata != '0) || (interval_reg != '0);
                    nd_next    = cfg_wdata;
                end
                REG_INTERVAL: begin
                    interval_next = cfg_wdata;
                    armed_next    = (start_reg != '0) || (cfg_wdata != '0);
                    nd_next       = ((start_reg != '0) || (cfg_wdata != '0)) ? start_reg : '0;
                end
                REG_NUMER: begin
                    numer_next = cfg_wdata[RATIO_W-1:0];
                end
                REG_DENOM: begin
                    denom_next = cfg_wdata[RATIO_W-1:0];
                end
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end else if (core_done && take) begin
            // commit the read's outcome to the timer state
            nd_next    = core_res.deadline_ns;
            armed_next = core_res.still_armed;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (core_done && take) begin
            m_valid_next = 1'b1;
            out_next     = core_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= '0;
            interval_reg <= '0;
            numer_reg    <= RATIO_W'(1);
            denom_reg    <= RATIO_W'(1);
            nd_reg       <= '0;
            armed_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            start_reg    <= start_next;
            interval_reg <= interval_next;
            numer_reg    <= numer_next;
            denom_reg    <= denom_next;
            nd_reg       <= nd_next;
            armed_reg    <= armed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_expirations    = out_reg.expirations;
    assign m_deadline_ns    = out_reg.deadline_ns;
    assign m_deadline_ticks = out_reg.deadline_ticks;
    assign m_still_armed    = out_reg.still_armed;
    assign m_saturated      = out_reg.saturated;

`include "periodic_timer_overrun_counter_top_defines.svh"

    // a disarmed timer always holds a zero deadline
    `PTOC_ASSERT(a_disarmed_zero, aclk, aresetn, armed_reg || (nd_reg == '0))
    // an accepted transaction makes the block busy
    `PTOC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_ready)
    // a finished result handed over shows up at the output
    `PTOC_ASSERT_NXT(a_result_loaded, aclk, aresetn, core_done && take, m_valid)
    // disarmed results carry no deadline, clamping only while armed
    `PTOC_ASSERT(a_disarmed_out, aclk, aresetn,
        !m_valid || m_still_armed
        || ((m_deadline_ns == '0) && (m_deadline_ticks == '0) && !m_saturated))

endmodule

`default_nettype wire

FILE: verif/periodic_timer_overrun_counter_top_tb.sv
// Self-checking testbench of the periodic timer overrun counter, with a local timer predictor.
`timescale 1ns / 1ps

module periodic_timer_overrun_counter_top_tb;
    import ptoc_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000; // watchdog bound for the whole run
    localparam int DRAIN_CYCLES   = 250;       // quiet time after the last result, longer than the slowest read
    localparam int TOTAL_READS    = 850;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_REGS       = 4;
    localparam int FIRST_UNMAPPED = 4;         // indexes from here up are not decoded

    // Predicts each timer read and holds the results still owed by the block.
    class overrun_tracker;
        time_t       start_ns;
        time_t       reload_ns;
        ratio_t      numer;
        ratio_t      denom;
        time_t       deadline;
        bit          armed;
        res_t        pending_reads[$];
        int unsigned failures;
        int unsigned results_seen;

        function new();
            start_ns     = '0;
            reload_ns    = '0;
            numer        = 1;
            denom        = 1;
            deadline     = '0;
            armed        = 1'b0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%s", msg);
            end
        endfunction

        // start or interval write re-arms at the start deadline; ratio writes don't
        function void apply_write(logic [IDX_W-1:0] idx, time_t data);
            case (idx)
                REG_START:    start_ns    = data;
                REG_INTERVAL: reload_ns   = data;
                REG_NUMER:    numer       = data[RATIO_W-1:0];
                REG_DENOM:    denom       = data[RATIO_W-1:0];
                default: return;
            endcase
            if (idx == REG_START || idx == REG_INTERVAL) begin
                armed    = (start_ns != 0) || (reload_ns != 0);
                deadline = armed ? start_ns : '0;
            end
        endfunction

        function res_t advance_timer(time_t now);
            logic [ALU_W-1:0]   missed;
            logic [ALU_W-1:0]   next_dl;
            logic [ALU_W-1:0]   count;
            logic [2*ALU_W-1:0] product;
            ratio_t             divisor;
            res_t               r;
            r = '0;
            if (armed && now >= deadline) begin
                if (reload_ns != 0) begin
                    // whole periods skipped, then move one period past now
                    missed  = (ALU_W'(now) - ALU_W'(deadline)) / ALU_W'(reload_ns);
                    next_dl = ALU_W'(deadline) + missed * ALU_W'(reload_ns)
                              + ALU_W'(reload_ns);
                    count   = missed + 1;
                    r.expirations = (count > ALU_W'(TIME_MAX)) ? TIME_MAX : count[TIME_W-1:0];
                    if (next_dl > ALU_W'(TIME_MAX)) begin
                        next_dl     = ALU_W'(TIME_MAX);
                        r.saturated = 1'b1;
                    end
                    deadline = next_dl[TIME_W-1:0];
                end else begin
                    // one-shot fires once and disarms
                    r.expirations = 1;
                    armed         = 1'b0;
                    deadline      = '0;
                end
            end
            if (armed) begin
                divisor          = (numer == 0) ? ratio_t'(1) : numer;
                product          = (2*ALU_W)'(deadline) * (2*ALU_W)'(denom);
                r.deadline_ns    = deadline;
                r.deadline_ticks = tick_t'(product / (2*ALU_W)'(divisor));
                r.still_armed    = 1'b1;
            end
            return r;
        endfunction

        function void log_read(time_t now);
            pending_reads.push_back(advance_timer(now));
        endfunction

        function void match_result(res_t got);
            res_t want;
            results_seen++;
            if (pending_reads.size() == 0) begin
                flag($sformatf("result %0d arrived with no read outstanding", results_seen));
                return;
            end
            want = pending_reads.pop_front();
            if (got !== want) begin
                flag($sformatf({"result %0d mismatch: expirations %0d/%0d deadline_ns %0d/%0d",
                                " deadline_ticks %0d/%0d still_armed %0b/%0b saturated %0b/%0b",
                                " (expected/actual)"},
                               results_seen, want.expirations, got.expirations,
                               want.deadline_ns, got.deadline_ns,
                               want.deadline_ticks, got.deadline_ticks,
                               want.still_armed, got.still_armed,
                               want.saturated, got.saturated));
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    time_t                cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    time_t                s_now_ns;
    logic                 m_valid;
    logic                 m_ready;
    time_t                m_expirations;
    time_t                m_deadline_ns;
    tick_t                m_deadline_ticks;
    logic                 m_still_armed;
    logic                 m_saturated;

    overrun_tracker ledger = new();
    bit             idle_on = 1'b1;   // cleared for back-to-back phases
    int unsigned    reads_sent = 0;
    int unsigned    cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    periodic_timer_overrun_counter_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_ns         (s_now_ns),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_expirations    (m_expirations),
        .m_deadline_ns    (m_deadline_ns),
        .m_deadline_ticks (m_deadline_ticks),
        .m_still_armed    (m_still_armed),
        .m_saturated      (m_saturated)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic time_t rand_time();
        return time_t'({$urandom, $urandom});
    endfunction

    // Read time aimed at the current deadline: just before, on it, on or just before
    // later period boundaries, a little past them, at either end of the range, or anywhere at all.
    function automatic time_t pick_now();
        logic [TIME_W+2:0] base;
        logic [TIME_W+2:0] v;
        int unsigned       off;
        base = {3'b000, ledger.deadline};
        case ($urandom_range(0, 9))
            0: v = {3'b000, rand_time()};
            1: v = $urandom_range(0, 1) ? {3'b000, TIME_MAX} : '0;
            2, 3: begin
                off = $urandom_range(1, 64);
                v   = (base > off) ? base - off : '0;
            end
            4: v = base;
            5, 6: v = base + ledger.reload_ns * $urandom_range(0, 3) + $urandom_range(0, 255);
            7: v = base + $urandom;
            default: v = base + ledger.reload_ns * $urandom_range(1, 4) - $urandom_range(0, 1);
        endcase
        return (v > TIME_MAX) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    // Drop valid and wait until every read has come back; the block is idle then.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ledger.pending_reads.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input time_t data);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        ledger.apply_write(idx, data);
    endtask

    // One read transaction; valid stays up from one item to the next when no gap is drawn.
    task automatic send_read(input time_t now_val);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_now_ns <= now_val;
        do @(posedge aclk); while (!s_ready);
        ledger.log_read(now_val);
        reads_sent++;
    endtask

    // New random settings, registers in rotated order, some left as they are.
    task automatic program_phase();
        int               first;
        logic [IDX_W-1:0] idx;
        time_t            v;
        ratio_t           ratio;
        first = $urandom_range(0, NUM_REGS - 1);
        for (int k = 0; k < NUM_REGS; k++) begin
            idx = IDX_W'((first + k) % NUM_REGS);
            case ($urandom_range(0, 5))
                0: ratio = '0;
                1: ratio = 1;
                2: ratio = $urandom;
                3: ratio = '1;
                default: ratio = $urandom_range(1, 1000);
            endcase
            case (idx)
                REG_START: begin
                    case ($urandom_range(0, 5))
                        0: v = '0;
                        1: v = time_t'($urandom_range(0, 2000));
                        2: v = rand_time();
                        3: v = TIME_MAX;
                        4: v = TIME_MAX - $urandom_range(0, 1000);
                        default: v = time_t'({$urandom_range(0, 255), $urandom});
                    endcase
                end
                REG_INTERVAL: begin
                    case ($urandom_range(0, 5))
                        0: v = '0;
                        1: v = 1;
                        2: v = time_t'($urandom_range(1, 500));
                        3: v = rand_time();
                        4: v = TIME_MAX;
                        default: v = time_t'({$urandom_range(0, 255), $urandom});
                    endcase
                end
                default: v = {31'($urandom), ratio};   // upper bits must be dropped
            endcase
            if ($urandom_range(0, 4) != 0) begin
                write_reg(idx, v);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg(IDX_W'($urandom_range(FIRST_UNMAPPED, 2**IDX_W - 1)), rand_time());
        end
    endtask

    // Result side: random stall before each transaction, checked on accept.
    initial begin
        int   stall;
        res_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            @(negedge aclk);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{expirations:    m_expirations,
                    deadline_ns:    m_deadline_ns,
                    deadline_ticks: m_deadline_ticks,
                    still_armed:    m_still_armed,
                    saturated:      m_saturated};
            ledger.match_result(got);
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_START;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_now_ns  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // disarmed out of reset
        send_read('0);
        send_read(TIME_MAX);
        // one-shot at 100: not due, fires, then stays disarmed
        write_reg(REG_START, 100);
        send_read(99);
        send_read(100);
        send_read(500);
        // periodic with start zero: armed at deadline 0
        write_reg(REG_INTERVAL, 10);
        write_reg(REG_START, '0);
        send_read('0);
        send_read(35);                                 // two periods missed
        write_reg(REG_NUMER, 3);
        write_reg(REG_DENOM, 7);                       // ratio writes keep the deadline
        send_read(39);
        write_reg(REG_NUMER, {31'h2AAA_AAAA, 32'd0});  // low word zero acts as divisor 1
        send_read(40);
        write_reg(REG_DENOM, '0);                      // zero multiplier, zero ticks
        send_read(41);
        write_reg(IDX_W'(FIRST_UNMAPPED), rand_time()); // not decoded
        send_read(50);
        // deadline advance past the top of the time range clamps
        write_reg(REG_NUMER, time_t'(32'hFFFF_FFFF));
        write_reg(REG_DENOM, time_t'(32'hFFFF_FFFF));
        write_reg(REG_START, TIME_MAX - 5);
        write_reg(REG_INTERVAL, TIME_MAX);
        send_read(TIME_MAX - 6);
        send_read(TIME_MAX);
        send_read(TIME_MAX);
        // unit interval from zero to the top: expiration count clamps too
        write_reg(REG_START, '0);
        write_reg(REG_INTERVAL, 1);
        send_read(TIME_MAX);
        write_reg(REG_NUMER, 1);
        send_read('0);                                 // widest tick product
        // both zero disarms
        write_reg(REG_INTERVAL, '0);
        write_reg(REG_START, '0);
        send_read(TIME_MAX);
        // one-shot at the last representable time
        write_reg(REG_START, TIME_MAX);
        send_read(TIME_MAX - 1);
        send_read(TIME_MAX);

        // --- random phases ---
        while (reads_sent < TOTAL_READS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            program_phase();
            repeat ($urandom_range(4, 30)) send_read(pick_now());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);   // nothing further may show up
        if (ledger.failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
